### rtl/gsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gsa_pkg;

   localparam int NODE_IDX_W  = 6;
   localparam int ACT_W       = 16;
   localparam int WEIGHT_W    = 16;
   localparam int KEEP_W      = 17;
   localparam int SUM_W       = 24;
   localparam int PROD_W      = 32;
   localparam int SCALED_W    = 49;
   localparam int PULSE_W     = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [ACT_W-1:0] ACT_ONE = 16'd32768;
   localparam logic [SUM_W-1:0] SUM_MAX = 24'hFFFFFF;

   localparam logic [2:0] ACTION_ADD_NODE = 3'd0;
   localparam logic [2:0] ACTION_ADD_EDGE = 3'd1;
   localparam logic [2:0] ACTION_SET_ACT  = 3'd2;
   localparam logic [2:0] ACTION_PULSE    = 3'd3;
   localparam logic [2:0] ACTION_RESET    = 3'd4;
   localparam logic [2:0] ACTION_READ     = 3'd5;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISSING = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSES    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE      = 2'd3;

   typedef struct packed {
      logic [2:0]            action;
      logic [NODE_IDX_W-1:0] first_node;
      logic [NODE_IDX_W-1:0] second_node;
      logic [15:0]           amount;
      logic                  both_ways;
      logic [PULSE_W-1:0]    pulse_count;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [ACT_W-1:0] activation_out;
      logic             node_present;
   } rsp_type;

   typedef struct packed {
      logic [NODE_IDX_W-1:0] src;
      logic [NODE_IDX_W-1:0] dst;
      logic [WEIGHT_W-1:0]   weight;
   } edge_type;

   typedef struct packed {
      logic mul_en;
      logic scale_en;
   } term_ctrl_type;

endpackage
`default_nettype wire

### rtl/gsa_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gsa_req_if;
   logic             valid;
   logic             ready;
   gsa_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface gsa_rsp_if;
   logic             valid;
   logic             ready;
   gsa_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/gsa_term_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-stage product act * weight * keep.
module gsa_term_unit (
   input  logic                             clock,
   input  gsa_pkg::term_ctrl_type           ctrl,
   input  logic [gsa_pkg::ACT_W-1:0]        act,
   input  logic [gsa_pkg::WEIGHT_W-1:0]     weight,
   input  logic [gsa_pkg::KEEP_W-1:0]       keep,
   output logic [gsa_pkg::SCALED_W-1:0]     scaled
);
   import gsa_pkg::*;

   logic [PROD_W-1:0]   prod_ff;
   logic [SCALED_W-1:0] scaled_ff;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= act * weight;
      end
      if (ctrl.scale_en) begin
         scaled_ff <= SCALED_W'(prod_ff) * SCALED_W'(keep);
      end
   end

   assign scaled = scaled_ff;
endmodule
`default_nettype wire

### rtl/graph_spreading_activation_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Spreading-activation graph engine. Nodes (activation Q1.15, base Q1.15) and weighted
// directed edges (Q2.14) live in synchronous memories with registered reads; one
// transfer on req_if gives exactly one transfer on rsp_if. After reset a clearing pass
// zeroes the spread accumulators while req_if.ready stays low. In a pulse item each
// edge reads the edge table, then both activations, runs the two-stage multiply and
// read-modify-writes the accumulator memory through its single write port; then every
// node folds its accumulator into its activation.
// A finished result waits in an output register, so the next item may be accepted early.
module graph_spreading_activation_core #(
   parameter int NODE_COUNT = 64,
   parameter int EDGE_COUNT = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   gsa_req_if.sink                         req_if,
   gsa_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [gsa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gsa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gsa_pkg::*;

   localparam int NODE_AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int EDGE_AW = $clog2(EDGE_COUNT);
   localparam int EDGE_CW = $clog2(EDGE_COUNT + 1);
   localparam logic [NODE_AW-1:0] NODE_LAST = NODE_AW'(NODE_COUNT - 1);
   localparam logic [EDGE_CW-1:0] EDGE_CAP  = EDGE_CW'(EDGE_COUNT);

   typedef enum logic [16:0] {
      ST_CLEAR    = 17'b00000000000000001,
      ST_IDLE     = 17'b00000000000000010,
      ST_EDGE2    = 17'b00000000000000100,
      ST_PSTART   = 17'b00000000000001000,
      ST_E_RD     = 17'b00000000000010000,
      ST_E_ACT    = 17'b00000000000100000,
      ST_E_MUL1   = 17'b00000000001000000,
      ST_E_MUL2   = 17'b00000000010000000,
      ST_E_ADD    = 17'b00000000100000000,
      ST_E_WRS    = 17'b00000001000000000,
      ST_N_RD     = 17'b00000010000000000,
      ST_N_MUL    = 17'b00000100000000000,
      ST_N_WR     = 17'b00001000000000000,
      ST_BASE_RD  = 17'b00010000000000000,
      ST_BASE_WR  = 17'b00100000000000000,
      ST_F_RD     = 17'b01000000000000000,
      ST_F_OUT    = 17'b10000000000000000
   } state_type;

   // configuration registers
   logic [15:0]        decay_ff, thresh_ff, base_lvl_ff;
   logic [PULSE_W-1:0] defpulse_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff    <= 16'd32768;
         thresh_ff   <= 16'd3277;
         defpulse_ff <= 8'd10;
         base_lvl_ff <= 16'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DECAY:     decay_ff    <= csr_wdata;
            CSR_THRESHOLD: thresh_ff   <= csr_wdata;
            CSR_PULSES:    defpulse_ff <= csr_wdata[PULSE_W-1:0];
            CSR_BASE:      base_lvl_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control and item registers
   state_type             state_ff, state_in;
   logic [NODE_IDX_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [15:0]           amount_ff, amount_in;
   logic [1:0]            status_ff, status_in;
   logic [PULSE_W-1:0]    pulses_ff, pulses_in;
   logic [NODE_AW-1:0]    node_idx_ff, node_idx_in;
   logic [EDGE_CW-1:0]    edge_idx_ff, edge_idx_in;
   logic [EDGE_CW-1:0]    edge_count_ff, edge_count_in;
   logic [NODE_COUNT-1:0] present_ff, present_in;
   logic [NODE_IDX_W-1:0] src_ff, src_in, dst_ff, dst_in;
   logic [WEIGHT_W-1:0]   weight_ff, weight_in;
   logic                  fwd_ff, fwd_in, bwd_ff, bwd_in;
   logic [SUM_W-1:0]      ns_ff, ns_in;
   logic [PROD_W-1:0]     dec_ff, dec_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // memory ports
   logic                  act_we, act_re0, act_re1;
   logic [NODE_AW-1:0]    act_wa, act_ra0, act_ra1;
   logic [ACT_W-1:0]      act_wd, act_rd0_ff, act_rd1_ff;
   logic                  sum_we, sum_re0, sum_re1;
   logic [NODE_AW-1:0]    sum_wa, sum_ra0, sum_ra1;
   logic [SUM_W-1:0]      sum_wd, sum_rd0_ff, sum_rd1_ff;
   logic                  base_we, base_re;
   logic [NODE_AW-1:0]    base_wa, base_ra;
   logic [ACT_W-1:0]      base_wd, base_rd_ff;
   logic                  edge_we, edge_re;
   logic [EDGE_AW-1:0]    edge_wa, edge_ra;
   edge_type              edge_wd, edge_rd_ff;

   logic [ACT_W-1:0]  act_mem  [NODE_COUNT];
   logic [SUM_W-1:0]  sum_mem  [NODE_COUNT];
   logic [ACT_W-1:0]  base_mem [NODE_COUNT];
   edge_type          edge_mem [EDGE_COUNT];

   always_ff @(posedge clock) begin
      if (act_we) act_mem[act_wa] <= act_wd;
      if (act_re0) act_rd0_ff <= act_mem[act_ra0];
      if (act_re1) act_rd1_ff <= act_mem[act_ra1];
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_wa] <= sum_wd;
      if (sum_re0) sum_rd0_ff <= sum_mem[sum_ra0];
      if (sum_re1) sum_rd1_ff <= sum_mem[sum_ra1];
   end

   always_ff @(posedge clock) begin
      if (base_we) base_mem[base_wa] <= base_wd;
      if (base_re) base_rd_ff <= base_mem[base_ra];
   end

   always_ff @(posedge clock) begin
      if (edge_we) edge_mem[edge_wa] <= edge_wd;
      if (edge_re) edge_rd_ff <= edge_mem[edge_ra];
   end

   // term multipliers: forward uses the source activation, backward the target
   term_ctrl_type         term_ctrl;
   logic [KEEP_W-1:0]     keep;
   logic [SCALED_W-1:0]   fwd_scaled, bwd_scaled;

   assign keep = 17'h10000 - KEEP_W'(decay_ff);

   gsa_term_unit u_fwd (
      .clock (clock), .ctrl (term_ctrl), .act (act_rd0_ff), .weight (weight_ff),
      .keep (keep), .scaled (fwd_scaled)
   );

   gsa_term_unit u_bwd (
      .clock (clock), .ctrl (term_ctrl), .act (act_rd1_ff), .weight (weight_ff),
      .keep (keep), .scaled (bwd_scaled)
   );

   function automatic logic [NODE_AW-1:0] to_addr(input logic [NODE_IDX_W-1:0] n);
      return NODE_AW'(n);
   endfunction

   function automatic logic node_ok(input logic [NODE_IDX_W-1:0] n,
                                    input logic [NODE_COUNT-1:0] pm);
      return (int'(n) < NODE_COUNT) && pm[NODE_AW'(n)];
   endfunction

   function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W:0] v);
      return (v > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : v[SUM_W-1:0];
   endfunction

   logic [SUM_W-1:0]   new_t, s_base;
   logic [SUM_W:0]     node_v;
   logic [PULSE_W-1:0] req_pulses;
   logic [1:0]         edge_need;
   logic [EDGE_CW-1:0] edge_next;
   req_type            req;

   assign req = req_if.data;

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      amount_in     = amount_ff;
      status_in     = status_ff;
      pulses_in     = pulses_ff;
      node_idx_in   = node_idx_ff;
      edge_idx_in   = edge_idx_ff;
      edge_count_in = edge_count_ff;
      present_in    = present_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      weight_in     = weight_ff;
      fwd_in        = fwd_ff;
      bwd_in        = bwd_ff;
      ns_in         = ns_ff;
      dec_in        = dec_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in   = rsp_data_ff;

      act_we = 1'b0; act_wa = '0; act_wd = '0;
      act_re0 = 1'b0; act_ra0 = '0; act_re1 = 1'b0; act_ra1 = '0;
      sum_we = 1'b0; sum_wa = '0; sum_wd = '0;
      sum_re0 = 1'b0; sum_ra0 = '0; sum_re1 = 1'b0; sum_ra1 = '0;
      base_we = 1'b0; base_wa = '0; base_wd = '0;
      base_re = 1'b0; base_ra = '0;
      edge_we = 1'b0; edge_wa = '0; edge_wd = '0;
      edge_re = 1'b0; edge_ra = '0;
      term_ctrl = '0;

      req_pulses = (req.pulse_count != '0) ? req.pulse_count : defpulse_ff;
      edge_need  = req.both_ways ? 2'd2 : 2'd1;
      edge_next  = edge_idx_ff + EDGE_CW'(1);

      // forward term lands on the target, backward on the source
      new_t  = sat_sum({1'b0, sum_rd0_ff}
                       + (fwd_ff ? (SUM_W+1)'(fwd_scaled[SCALED_W-1:30]) : '0));
      s_base = (src_ff == dst_ff) ? new_t : sum_rd1_ff;
      node_v = (SUM_W+1)'(dec_ff[PROD_W-1:16]) + (SUM_W+1)'(sum_rd0_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            sum_we = 1'b1;
            sum_wa = node_idx_ff;
            if (node_idx_ff == NODE_LAST) begin
               node_idx_in = '0;
               state_in    = ST_IDLE;
            end else begin
               node_idx_in = node_idx_ff + NODE_AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_if.valid) begin
               a_in      = req.first_node;
               b_in      = req.second_node;
               amount_in = req.amount;
               status_in = STATUS_OK;
               state_in  = ST_F_RD;
               unique case (req.action)
                  ACTION_ADD_NODE: begin
                     if (int'(req.first_node) < NODE_COUNT) begin
                        present_in[to_addr(req.first_node)] = 1'b1;
                        act_we  = 1'b1;
                        act_wa  = to_addr(req.first_node);
                        act_wd  = '0;
                        base_we = 1'b1;
                        base_wa = to_addr(req.first_node);
                        base_wd = (base_lvl_ff > ACT_ONE) ? ACT_ONE : base_lvl_ff;
                     end else begin
                        status_in = STATUS_MISSING;
                     end
                  end
                  ACTION_ADD_EDGE: begin
                     if (!node_ok(req.first_node, present_ff) ||
                         !node_ok(req.second_node, present_ff)) begin
                        status_in = STATUS_MISSING;
                     end else if ((EDGE_CAP - edge_count_ff) < EDGE_CW'(edge_need)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        edge_we       = 1'b1;
                        edge_wa       = edge_count_ff[EDGE_AW-1:0];
                        edge_wd       = '{src: req.first_node, dst: req.second_node,
                                          weight: req.amount};
                        edge_count_in = edge_count_ff + EDGE_CW'(1);
                        if (req.both_ways) state_in = ST_EDGE2;
                     end
                  end
                  ACTION_SET_ACT: begin
                     if (node_ok(req.first_node, present_ff)) begin
                        act_we = 1'b1;
                        act_wa = to_addr(req.first_node);
                        act_wd = (req.amount > ACT_ONE) ? ACT_ONE : req.amount;
                     end else begin
                        status_in = STATUS_MISSING;
                     end
                  end
                  ACTION_PULSE: begin
                     pulses_in = req_pulses;
                     if (req_pulses != '0) state_in = ST_PSTART;
                  end
                  ACTION_RESET: begin
                     node_idx_in = '0;
                     state_in    = ST_BASE_RD;
                  end
                  ACTION_READ: begin
                     if (!node_ok(req.first_node, present_ff)) status_in = STATUS_MISSING;
                  end
                  default: ;
               endcase
            end
         end
         ST_EDGE2: begin
            // reverse edge goes in the next slot
            edge_we       = 1'b1;
            edge_wa       = edge_count_ff[EDGE_AW-1:0];
            edge_wd       = '{src: b_ff, dst: a_ff, weight: amount_ff};
            edge_count_in = edge_count_ff + EDGE_CW'(1);
            state_in      = ST_F_RD;
         end
         ST_PSTART: begin
            edge_idx_in = '0;
            node_idx_in = '0;
            state_in    = (edge_count_ff == '0) ? ST_N_RD : ST_E_RD;
         end
         ST_E_RD: begin
            edge_re  = 1'b1;
            edge_ra  = edge_idx_ff[EDGE_AW-1:0];
            state_in = ST_E_ACT;
         end
         ST_E_ACT: begin
            src_in    = edge_rd_ff.src;
            dst_in    = edge_rd_ff.dst;
            weight_in = edge_rd_ff.weight;
            act_re0   = 1'b1;
            act_ra0   = to_addr(edge_rd_ff.src);
            act_re1   = 1'b1;
            act_ra1   = to_addr(edge_rd_ff.dst);
            state_in  = ST_E_MUL1;
         end
         ST_E_MUL1: begin
            term_ctrl.mul_en = 1'b1;
            fwd_in   = act_rd0_ff >= thresh_ff;
            bwd_in   = act_rd1_ff >= thresh_ff;
            sum_re0  = 1'b1;
            sum_ra0  = to_addr(dst_ff);
            sum_re1  = 1'b1;
            sum_ra1  = to_addr(src_ff);
            state_in = ST_E_MUL2;
         end
         ST_E_MUL2: begin
            term_ctrl.scale_en = 1'b1;
            state_in = ST_E_ADD;
         end
         ST_E_ADD: begin
            sum_we   = 1'b1;
            sum_wa   = to_addr(dst_ff);
            sum_wd   = new_t;
            ns_in    = sat_sum({1'b0, s_base}
                       + (bwd_ff ? (SUM_W+1)'(bwd_scaled[SCALED_W-1:31]) : '0));
            state_in = ST_E_WRS;
         end
         ST_E_WRS: begin
            sum_we      = 1'b1;
            sum_wa      = to_addr(src_ff);
            sum_wd      = ns_ff;
            edge_idx_in = edge_next;
            state_in    = (edge_next < edge_count_ff) ? ST_E_RD : ST_N_RD;
         end
         ST_N_RD: begin
            act_re0  = 1'b1;
            act_ra0  = node_idx_ff;
            sum_re0  = 1'b1;
            sum_ra0  = node_idx_ff;
            state_in = ST_N_MUL;
         end
         ST_N_MUL: begin
            dec_in   = act_rd0_ff * decay_ff;
            state_in = ST_N_WR;
         end
         ST_N_WR: begin
            // fold the accumulator into the node and clear it for the next pulse
            act_we = present_ff[node_idx_ff];
            act_wa = node_idx_ff;
            act_wd = (node_v > (SUM_W+1)'(ACT_ONE)) ? ACT_ONE : node_v[ACT_W-1:0];
            sum_we = 1'b1;
            sum_wa = node_idx_ff;
            sum_wd = '0;
            if (node_idx_ff == NODE_LAST) begin
               node_idx_in = '0;
               pulses_in   = pulses_ff - PULSE_W'(1);
               state_in    = (pulses_ff == PULSE_W'(1)) ? ST_F_RD : ST_PSTART;
            end else begin
               node_idx_in = node_idx_ff + NODE_AW'(1);
               state_in    = ST_N_RD;
            end
         end
         ST_BASE_RD: begin
            base_re  = 1'b1;
            base_ra  = node_idx_ff;
            state_in = ST_BASE_WR;
         end
         ST_BASE_WR: begin
            act_we = present_ff[node_idx_ff];
            act_wa = node_idx_ff;
            act_wd = base_rd_ff;
            if (node_idx_ff == NODE_LAST) begin
               node_idx_in = '0;
               state_in    = ST_F_RD;
            end else begin
               node_idx_in = node_idx_ff + NODE_AW'(1);
               state_in    = ST_BASE_RD;
            end
         end
         ST_F_RD: begin
            act_re0  = 1'b1;
            act_ra0  = to_addr(a_ff);
            state_in = ST_F_OUT;
         end
         ST_F_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status         = status_ff;
               rsp_data_in.node_present   = node_ok(a_ff, present_ff);
               rsp_data_in.activation_out = node_ok(a_ff, present_ff) ? act_rd0_ff : '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         node_idx_ff   <= '0;
         edge_count_ff <= '0;
         present_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_idx_ff   <= node_idx_in;
         edge_count_ff <= edge_count_in;
         present_ff    <= present_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      amount_ff   <= amount_in;
      status_ff   <= status_in;
      pulses_ff   <= pulses_in;
      edge_idx_ff <= edge_idx_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      weight_ff   <= weight_in;
      fwd_ff      <= fwd_in;
      bwd_ff      <= bwd_in;
      ns_ff       <= ns_in;
      dec_ff      <= dec_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;
endmodule
`default_nettype wire

### rtl/gsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module gsa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input gsa_pkg::rsp_type rsp_data
);
   import gsa_pkg::*;

   // clearing pass holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_act_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.activation_out <= ACT_ONE)
      else $error("activation above one");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.node_present |-> rsp_data.activation_out == '0)
      else $error("missing node with nonzero activation");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_MISSING ||
                     rsp_data.status == STATUS_FULL))
      else $error("bad status code");
endmodule

bind graph_spreading_activation_core gsa_checker u_gsa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);
`default_nettype wire

### tb/sv/activation_checker.sv
`timescale 1ns / 1ps
module activation_checker
   import gsa_pkg::*;
#(
   parameter int NODE_COUNT = 64,
   parameter int EDGE_COUNT = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   gsa_req_if                     req_if,
   gsa_rsp_if                     rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   logic [15:0]      decay_q16;
   logic [15:0]      spread_floor;
   logic [7:0]       pulses_default;
   logic [15:0]      base_cfg;

   bit               present[NODE_COUNT];
   logic [ACT_W-1:0] level[NODE_COUNT];
   logic [ACT_W-1:0] base_of[NODE_COUNT];
   logic [SUM_W-1:0] incoming[NODE_COUNT];
   edge_type         links[EDGE_COUNT];
   int unsigned      link_total;

   rsp_type          expected_rsp[$];

   function automatic void add_incoming(int unsigned n, longint unsigned term);
      longint unsigned acc;
      acc = longint'(incoming[n]) + term;
      incoming[n] = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
   endfunction

   // One pulse: all terms use the levels from before the pulse.
   function automatic void spread_once();
      longint unsigned keep, prod, v;
      int unsigned     s, t;
      keep = 65536 - longint'(decay_q16);
      for (int n = 0; n < NODE_COUNT; n++) incoming[n] = '0;
      for (int unsigned i = 0; i < link_total; i++) begin
         s = links[i].src;
         t = links[i].dst;
         if (level[s] >= spread_floor) begin
            prod = longint'(level[s]) * longint'(links[i].weight) * keep;
            add_incoming(t, prod >> 30);
         end
         if (level[t] >= spread_floor) begin
            prod = longint'(level[t]) * longint'(links[i].weight) * keep;
            add_incoming(s, prod >> 31);
         end
      end
      for (int n = 0; n < NODE_COUNT; n++) begin
         if (present[n]) begin
            v = ((longint'(level[n]) * longint'(decay_q16)) >> 16) + longint'(incoming[n]);
            level[n] = (v > ACT_ONE) ? ACT_ONE : v[ACT_W-1:0];
         end
      end
   endfunction

   function automatic rsp_type predict_graph(req_type r);
      rsp_type     res;
      int unsigned a, b, need, count;
      a = r.first_node;
      b = r.second_node;
      res.status = STATUS_OK;
      case (r.action)
         ACTION_ADD_NODE: begin
            present[a] = 1'b1;
            level[a]   = '0;
            base_of[a] = (base_cfg > ACT_ONE) ? ACT_ONE : base_cfg;
         end
         ACTION_ADD_EDGE: begin
            need = r.both_ways ? 2 : 1;
            if (!present[a] || !present[b]) res.status = STATUS_MISSING;
            else if (EDGE_COUNT - link_total < need) res.status = STATUS_FULL;
            else begin
               links[link_total] = '{src: r.first_node, dst: r.second_node,
                                     weight: r.amount};
               link_total++;
               if (r.both_ways) begin
                  links[link_total] = '{src: r.second_node, dst: r.first_node,
                                        weight: r.amount};
                  link_total++;
               end
            end
         end
         ACTION_SET_ACT: begin
            if (present[a]) level[a] = (r.amount > ACT_ONE) ? ACT_ONE : r.amount;
            else res.status = STATUS_MISSING;
         end
         ACTION_PULSE: begin
            count = (r.pulse_count == 0) ? pulses_default : r.pulse_count;
            repeat (count) spread_once();
         end
         ACTION_RESET: begin
            for (int n = 0; n < NODE_COUNT; n++) if (present[n]) level[n] = base_of[n];
         end
         ACTION_READ: begin
            if (!present[a]) res.status = STATUS_MISSING;
         end
         default: ;
      endcase
      res.activation_out = present[a] ? level[a] : '0;
      res.node_present   = present[a];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         decay_q16      = 16'd32768;
         spread_floor   = 16'd3277;
         pulses_default = 8'd10;
         base_cfg       = 16'd0;
         for (int n = 0; n < NODE_COUNT; n++) begin
            present[n] = 1'b0;
            level[n]   = '0;
            base_of[n] = '0;
            incoming[n] = '0;
         end
         link_total = 0;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("result with no expectation waiting: %p", rsp_if.data);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_if.data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_if.data.status);
                  fail_count++;
               end
               if (rsp_if.data.activation_out !== want.activation_out) begin
                  $error("activation_out: expected %0d, got %0d",
                         want.activation_out, rsp_if.data.activation_out);
                  fail_count++;
               end
               if (rsp_if.data.node_present !== want.node_present) begin
                  $error("node_present: expected %0d, got %0d",
                         want.node_present, rsp_if.data.node_present);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DECAY:     decay_q16      = csr_wdata;
               CSR_THRESHOLD: spread_floor   = csr_wdata;
               CSR_PULSES:    pulses_default = csr_wdata[7:0];
               CSR_BASE:      base_cfg       = csr_wdata;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready)
            expected_rsp = {expected_rsp, predict_graph(req_if.data)};
      end
      pending = expected_rsp.size();
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
   import gsa_pkg::*;

   // Actions the block leaves unused; they must change nothing.
   localparam logic [2:0] ACTION_SPARE_LO = 3'd6;
   localparam logic [2:0] ACTION_SPARE_HI = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     pending;

   gsa_req_if req_ch ();
   gsa_rsp_if rsp_ch ();

   graph_spreading_activation_core #(.NODE_COUNT(64), .EDGE_COUNT(256)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   activation_checker #(.NODE_COUNT(64), .EDGE_COUNT(256)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_ch),
      .rsp_if     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one, often none at all.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result side: hold ready high or low for random stretches.
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_ch.ready = 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         repeat (gap_length()) begin
            rsp_ch.ready = 1'b0;
            @(negedge clock);
         end
      end
   end

   function automatic req_type make_item(logic [2:0] act, int a, int b, int amount,
                                         bit both, int pulses);
      req_type r;
      r.action      = act;
      r.first_node  = NODE_IDX_W'(a);
      r.second_node = NODE_IDX_W'(b);
      r.amount      = 16'(amount);
      r.both_ways   = both;
      r.pulse_count = PULSE_W'(pulses);
      return r;
   endfunction

   // Present one item from a falling edge and hold it until the transfer.
   task automatic send(req_type r);
      int idle;
      idle = gap_length();
      if (idle > 0) begin
         req_ch.valid = 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.data  = r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and wait until every result is back, then let the block settle.
   task automatic drain();
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, int value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // Node indices lean on a small working set so that edges and pulses do real work.
   function automatic int pick_node();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 11) : $urandom_range(0, 63);
   endfunction

   function automatic req_type random_item();
      req_type r;
      int      roll;
      r    = make_item(ACTION_READ, pick_node(), pick_node(), $urandom_range(0, 65535),
                       1'($urandom_range(0, 1)), $urandom_range(1, 3));
      roll = $urandom_range(0, 99);
      if (roll < 10) r.action = ACTION_ADD_NODE;
      else if (roll < 32) r.action = ACTION_ADD_EDGE;
      else if (roll < 55) r.action = ACTION_SET_ACT;
      else if (roll < 67) r.action = ACTION_PULSE;
      else if (roll < 72) r.action = ACTION_RESET;
      else if (roll < 94) r.action = ACTION_READ;
      else r.action = $urandom_range(0, 1) ? ACTION_SPARE_LO : ACTION_SPARE_HI;
      if ($urandom_range(0, 4) == 0) r.amount = $urandom_range(0, 1) ? 16'd32768 : 16'hFFFF;
      if ($urandom_range(0, 4) == 0) r.pulse_count = '0;
      return r;
   endfunction

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset settings, missing nodes, saturation, threshold edge.
      send(make_item(ACTION_READ, 5, 0, 0, 0, 0));
      send(make_item(ACTION_SET_ACT, 5, 0, 1000, 0, 0));
      send(make_item(ACTION_ADD_EDGE, 0, 1, 100, 0, 0));
      send(make_item(ACTION_ADD_NODE, 0, 0, 0, 0, 0));
      send(make_item(ACTION_ADD_NODE, 63, 0, 0, 0, 0));
      send(make_item(ACTION_ADD_NODE, 1, 0, 0, 0, 0));
      send(make_item(ACTION_ADD_NODE, 2, 0, 0, 0, 0));
      send(make_item(ACTION_ADD_EDGE, 0, 5, 100, 1, 0));
      send(make_item(ACTION_ADD_EDGE, 0, 1, 16'hFFFF, 1, 0));
      send(make_item(ACTION_ADD_EDGE, 63, 2, 0, 0, 0));
      send(make_item(ACTION_ADD_EDGE, 2, 63, 16'h4000, 0, 0));
      send(make_item(ACTION_SET_ACT, 0, 0, 16'hFFFF, 0, 0));
      send(make_item(ACTION_SET_ACT, 63, 0, 32768, 0, 0));
      send(make_item(ACTION_SET_ACT, 1, 0, 3277, 0, 0));
      send(make_item(ACTION_SET_ACT, 2, 0, 3276, 0, 0));
      send(make_item(ACTION_PULSE, 0, 0, 0, 0, 1));
      send(make_item(ACTION_PULSE, 1, 0, 0, 0, 0));
      send(make_item(ACTION_READ, 63, 0, 0, 0, 0));
      send(make_item(ACTION_RESET, 0, 0, 0, 0, 0));
      send(make_item(ACTION_SPARE_LO, 0, 63, 16'hFFFF, 1, 8'hFF));
      send(make_item(ACTION_SPARE_HI, 63, 0, 0, 0, 0));
      send(make_item(ACTION_ADD_NODE, 1, 0, 0, 0, 0));
      drain();

      // Extremes at the low end; base above one must clamp to one.
      csr_write(CSR_DECAY, 0);
      csr_write(CSR_THRESHOLD, 0);
      csr_write(CSR_PULSES, 0);
      csr_write(CSR_BASE, 16'hFFFF);
      send(make_item(ACTION_ADD_NODE, 3, 0, 0, 0, 0));
      send(make_item(ACTION_ADD_NODE, 4, 0, 0, 0, 0));
      send(make_item(ACTION_RESET, 3, 0, 0, 0, 0));
      send(make_item(ACTION_PULSE, 3, 0, 0, 0, 0));
      send(make_item(ACTION_PULSE, 0, 0, 0, 0, 255));
      send(make_item(ACTION_READ, 1, 0, 0, 0, 0));
      drain();

      // Random work under three settings, the high extremes among them.
      csr_write(CSR_DECAY, 16'hFFFF);
      csr_write(CSR_THRESHOLD, 32768);
      csr_write(CSR_PULSES, 255);
      csr_write(CSR_PULSES, 2);
      csr_write(CSR_BASE, 32768);
      repeat (8) send(random_item());
      drain();

      csr_write(CSR_DECAY, $urandom_range(0, 65535));
      csr_write(CSR_THRESHOLD, $urandom_range(0, 8000));
      csr_write(CSR_PULSES, $urandom_range(0, 3));
      csr_write(CSR_BASE, $urandom_range(0, 32768));
      repeat (8) send(random_item());
      drain();

      csr_write(CSR_DECAY, 32768);
      csr_write(CSR_THRESHOLD, 3277);
      csr_write(CSR_PULSES, 1);
      csr_write(CSR_BASE, 1000);
      repeat (8) send(random_item());
      drain();

      // Fill the edge table to the top, then knock on it with both kinds of add edge.
      repeat (130) send(make_item(ACTION_ADD_EDGE, 0, 1, $urandom_range(0, 65535), 1, 0));
      send(make_item(ACTION_ADD_EDGE, 1, 0, 16'h1234, 0, 0));
      send(make_item(ACTION_ADD_EDGE, 1, 0, 16'h1234, 0, 0));
      send(make_item(ACTION_SET_ACT, 0, 0, 20000, 0, 0));
      send(make_item(ACTION_PULSE, 0, 0, 0, 0, 1));
      send(make_item(ACTION_READ, 1, 0, 0, 0, 0));
      drain();

      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #100_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### filelist.f
rtl/gsa_pkg.sv
rtl/gsa_if.sv
rtl/gsa_term_unit.sv
rtl/graph_spreading_activation_core.sv
rtl/gsa_checker.sv
tb/sv/activation_checker.sv
tb/sv/tb.sv
